// ===== rtl/grid_line_raycast_top_assert.svh =====
// ----------------------------------------------------------------------------
// Grid line raycast assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef GRID_LINE_RAYCAST_TOP_ASSERT_SVH
`define GRID_LINE_RAYCAST_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/glr_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid line raycast package
// Types, codes and widths shared by the raycast modules.
// ----------------------------------------------------------------------------
package glr_pkg;

  localparam int unsigned CoordW = 10;
  localparam int unsigned CfgW   = 9;
  localparam int unsigned HitW   = 8;

  typedef logic [CoordW-1:0] glr_coord_t;

  typedef enum logic [1:0] {
    CMD_MARK  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_CAST  = 2'd2
  } glr_cmd_e;

  typedef enum logic {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } glr_cfg_e;

  typedef enum logic [1:0] {
    PRB_SIDE_A,
    PRB_SIDE_B,
    PRB_NEW
  } glr_probe_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_INIT,
    ST_FIRST,
    ST_PROBE,
    ST_DRAIN,
    ST_RESULT
  } glr_state_e;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
  } glr_walk_ctl_t;

  typedef struct packed {
    glr_coord_t x;
    glr_coord_t y;
    glr_coord_t px;
    glr_coord_t py;
    logic       at_end;
    logic       step_diag;
  } glr_walk_sts_t;

endpackage

// ===== rtl/glr_ram.sv =====
// ----------------------------------------------------------------------------
// Grid line raycast RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module glr_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/glr_walk.sv =====
// ----------------------------------------------------------------------------
// Grid line raycast walker
// Holds the line position and error term and advances them one step at a time.
// ----------------------------------------------------------------------------
module glr_walk (
  input  logic                   clk_i,
  input  glr_pkg::glr_walk_ctl_t ctl_i,
  input  glr_pkg::glr_coord_t    from_x_i,
  input  glr_pkg::glr_coord_t    from_y_i,
  input  glr_pkg::glr_coord_t    to_x_i,
  input  glr_pkg::glr_coord_t    to_y_i,
  output glr_pkg::glr_walk_sts_t sts_o
);
  import glr_pkg::*;

  glr_coord_t         x_q, x_d, y_q, y_d;
  glr_coord_t         px_q, px_d, py_q, py_d;
  glr_coord_t         bx_q, bx_d, by_q, by_d;
  logic [10:0]        dx_q, dx_d, dy_q, dy_d;
  logic               sxn_q, sxn_d, syn_q, syn_d;
  logic signed [12:0] err_q, err_d;

  logic signed [10:0] diff_x, diff_y;
  logic [10:0]        abs_x, abs_y;
  logic signed [13:0] e2;
  logic               mvx, mvy;
  logic signed [12:0] err_step;
  glr_coord_t         x_step, y_step;

  always_comb begin
    diff_x = $signed({x_q[CoordW-1], x_q}) - $signed({bx_q[CoordW-1], bx_q});
    diff_y = $signed({y_q[CoordW-1], y_q}) - $signed({by_q[CoordW-1], by_q});
    abs_x  = diff_x[10] ? 11'(-diff_x) : 11'(diff_x);
    abs_y  = diff_y[10] ? 11'(-diff_y) : 11'(diff_y);

    e2  = {err_q, 1'b0};
    mvx = e2 > -$signed({3'b000, dy_q});
    mvy = e2 < $signed({3'b000, dx_q});
    err_step = err_q - (mvx ? $signed({2'b00, dy_q}) : 13'sd0)
                     + (mvy ? $signed({2'b00, dx_q}) : 13'sd0);
    x_step = mvx ? (sxn_q ? x_q - 10'd1 : x_q + 10'd1) : x_q;
    y_step = mvy ? (syn_q ? y_q - 10'd1 : y_q + 10'd1) : y_q;
  end

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    px_d  = px_q;
    py_d  = py_q;
    bx_d  = bx_q;
    by_d  = by_q;
    dx_d  = dx_q;
    dy_d  = dy_q;
    sxn_d = sxn_q;
    syn_d = syn_q;
    err_d = err_q;
    if (ctl_i.load) begin
      x_d  = from_x_i;
      y_d  = from_y_i;
      px_d = from_x_i;
      py_d = from_y_i;
      bx_d = to_x_i;
      by_d = to_y_i;
    end else if (ctl_i.init) begin
      dx_d  = abs_x;
      dy_d  = abs_y;
      sxn_d = !diff_x[10] && (diff_x != 11'sd0);
      syn_d = !diff_y[10] && (diff_y != 11'sd0);
      err_d = $signed({2'b00, abs_x}) - $signed({2'b00, abs_y});
    end else if (ctl_i.step) begin
      px_d  = x_q;
      py_d  = y_q;
      x_d   = x_step;
      y_d   = y_step;
      err_d = err_step;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    px_q  <= px_d;
    py_q  <= py_d;
    bx_q  <= bx_d;
    by_q  <= by_d;
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    sxn_q <= sxn_d;
    syn_q <= syn_d;
    err_q <= err_d;
  end

  always_comb begin
    sts_o.x         = x_q;
    sts_o.y         = y_q;
    sts_o.px        = px_q;
    sts_o.py        = py_q;
    sts_o.at_end    = (x_q == bx_q) && (y_q == by_q);
    sts_o.step_diag = mvx && mvy;
  end

endmodule

// ===== rtl/grid_line_raycast_top.sv =====
// ----------------------------------------------------------------------------
// Grid line raycast top level
// A one-bit occupancy grid that takes mark, clear and cast-ray commands. After
// reset the grid RAM is swept clear, one cell per cycle, over all
// 2**($clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT)) cells (65536 by default), and
// no command beat is taken until the sweep ends. A mark or clear command goes
// through the write and result states to the output register, and an unused
// command goes straight to the result state. A ray tests, one cell per cycle
// through the single read port of the grid RAM, the new cell of each straight
// step and the two side cells and the new cell of each diagonal step of its
// line; a ray stops early at the first occupied cell. The block takes one
// command at a time, and a new command may enter while the previous result
// beat still waits in the output register.
// ----------------------------------------------------------------------------
module grid_line_raycast_top #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic signed [9:0] from_x_i,
  input  logic signed [9:0] from_y_i,
  input  logic signed [9:0] to_x_i,
  input  logic signed [9:0] to_y_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              hit_o,
  output logic [7:0]        hit_x_o,
  output logic [7:0]        hit_y_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [8:0]        cfg_data_i
);
  import glr_pkg::*;

  `include "grid_line_raycast_top_assert.svh"

  localparam int unsigned XAddrW    = $clog2(MAX_WIDTH);
  localparam int unsigned YAddrW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AddrW     = XAddrW + YAddrW;
  localparam int unsigned CellCount = 2 ** AddrW;
  localparam int unsigned ExtW      = (AddrW > CfgW) ? AddrW : CfgW;

  glr_state_e    state_q, state_d;
  glr_probe_e    pidx_q, pidx_d;
  logic [1:0]    cmd_q, cmd_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [CfgW-1:0]  cfg_w_q, cfg_h_q;
  logic [CfgW-1:0]  eff_w, eff_h;

  glr_walk_ctl_t walk_ctl;
  glr_walk_sts_t walk_sts;

  glr_coord_t       pc_x, pc_y;
  logic             cell_in;
  logic [ExtW-1:0]  ext_x, ext_y;
  logic [AddrW-1:0] cell_addr;
  logic             ram_we, ram_wdata;
  logic [0:0]       ram_rdata;

  logic            issue;
  logic            pend_q;
  logic            pend_in_q;
  logic [HitW-1:0] pend_x_q, pend_y_q;
  logic            hit_now;

  logic            res_set, res_hit_d;
  logic            res_hit_q;
  logic [HitW-1:0] res_x_q, res_y_q;
  logic            out_load;
  logic            out_valid_q, out_hit_q;
  logic [HitW-1:0] out_x_q, out_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 9'd256;
      cfg_h_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GRID_WIDTH:  cfg_w_q <= cfg_data_i;
        CFG_GRID_HEIGHT: cfg_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = (cfg_w_q == '0) ? 9'd1 :
            ((32'(cfg_w_q) > MAX_WIDTH) ? 9'(MAX_WIDTH) : cfg_w_q);
    eff_h = (cfg_h_q == '0) ? 9'd1 :
            ((32'(cfg_h_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : cfg_h_q);
  end

  glr_walk u_walk (
    .clk_i    (clk_i),
    .ctl_i    (walk_ctl),
    .from_x_i (from_x_i),
    .from_y_i (from_y_i),
    .to_x_i   (to_x_i),
    .to_y_i   (to_y_i),
    .sts_o    (walk_sts)
  );

  always_comb begin
    pc_x = walk_sts.x;
    pc_y = walk_sts.y;
    if (state_q == ST_PROBE) begin
      case (pidx_q)
        PRB_SIDE_A: pc_y = walk_sts.py;
        PRB_SIDE_B: pc_x = walk_sts.px;
        default: ;
      endcase
    end
    cell_in   = !pc_x[CoordW-1] && !pc_y[CoordW-1] &&
                (pc_x[CfgW-1:0] < eff_w) && (pc_y[CfgW-1:0] < eff_h);
    ext_x     = ExtW'(pc_x[CfgW-1:0]);
    ext_y     = ExtW'(pc_y[CfgW-1:0]);
    cell_addr = {ext_y[YAddrW-1:0], ext_x[XAddrW-1:0]};
  end

  glr_ram #(
    .WIDTH (1),
    .DEPTH (CellCount)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ((state_q == ST_CLEAR) ? clr_q : cell_addr),
    .wdata_i (ram_wdata),
    .raddr_i (cell_addr),
    .rdata_o (ram_rdata)
  );

  assign hit_now = pend_q && pend_in_q && ram_rdata[0];

  always_comb begin
    state_d   = state_q;
    pidx_d    = pidx_q;
    cmd_d     = cmd_q;
    clr_d     = clr_q;
    walk_ctl  = '0;
    issue     = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    res_set   = 1'b0;
    res_hit_d = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          walk_ctl.load = 1'b1;
          cmd_d         = command_i;
          case (command_i)
            CMD_MARK, CMD_CLEAR: state_d = ST_WRITE;
            CMD_CAST:            state_d = ST_INIT;
            default: begin
              res_set = 1'b1;
              state_d = ST_RESULT;
            end
          endcase
        end
      end
      ST_WRITE: begin
        ram_we    = cell_in;
        ram_wdata = (cmd_q == CMD_MARK);
        res_set   = 1'b1;
        state_d   = ST_RESULT;
      end
      ST_INIT: begin
        walk_ctl.init = 1'b1;
        state_d       = ST_FIRST;
      end
      ST_FIRST: begin
        if (walk_sts.at_end) begin
          issue   = 1'b1;
          state_d = ST_DRAIN;
        end else begin
          walk_ctl.step = 1'b1;
          pidx_d        = walk_sts.step_diag ? PRB_SIDE_A : PRB_NEW;
          state_d       = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (hit_now) begin
          res_set   = 1'b1;
          res_hit_d = 1'b1;
          state_d   = ST_RESULT;
        end else begin
          issue = 1'b1;
          case (pidx_q)
            PRB_SIDE_A: pidx_d = PRB_SIDE_B;
            PRB_SIDE_B: pidx_d = PRB_NEW;
            default: begin
              if (walk_sts.at_end) begin
                state_d = ST_DRAIN;
              end else begin
                walk_ctl.step = 1'b1;
                pidx_d        = walk_sts.step_diag ? PRB_SIDE_A : PRB_NEW;
              end
            end
          endcase
        end
      end
      ST_DRAIN: begin
        res_set   = 1'b1;
        res_hit_d = hit_now;
        state_d   = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    cmd_q  <= cmd_d;
    if (issue) begin
      pend_in_q <= cell_in;
      pend_x_q  <= pc_x[HitW-1:0];
      pend_y_q  <= pc_y[HitW-1:0];
    end
    if (res_set) begin
      res_hit_q <= res_hit_d;
      res_x_q   <= res_hit_d ? pend_x_q : '0;
      res_y_q   <= res_hit_d ? pend_y_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hit_q <= res_hit_q;
      out_x_q   <= res_x_q;
      out_y_q   <= res_y_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign hit_x_o     = out_x_q;
  assign hit_y_o     = out_y_q;

  `GLR_ASSERT_SAME(a_hit_in_grid, out_valid_o && hit_o,
    ({1'b0, hit_x_o} < eff_w) && ({1'b0, hit_y_o} < eff_h),
    "reported hit cell lies outside the grid")
  `GLR_ASSERT_SAME(a_miss_zero, out_valid_o && !hit_o,
    (hit_x_o == 8'd0) && (hit_y_o == 8'd0),
    "miss beat carries nonzero coordinates")
  `GLR_ASSERT_SAME(a_write_no_hit, (state_q == ST_RESULT) && (cmd_q != CMD_CAST),
    !res_hit_q, "write command produced a hit")
  `GLR_ASSERT_SAME(a_out_from_result, $rose(out_valid_o),
    $past(state_q) == ST_RESULT, "result beat appeared outside the result state")
  `GLR_ASSERT_NEXT(a_probe_issues, (state_q == ST_PROBE) && !hit_now,
    pend_q, "probe cycle did not leave a cell test in flight")

endmodule
